FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/uep0_pkg.sv
package uep0_pkg;

   // Control transfer phases.
   localparam logic [2:0] PH_IN_DATA         = 3'd0;
   localparam logic [2:0] PH_LAST_IN         = 3'd1;
   localparam logic [2:0] PH_WAIT_STATUS_OUT = 3'd2;
   localparam logic [2:0] PH_WAIT_STATUS_IN  = 3'd3;
   localparam logic [2:0] PH_SETTING_UP      = 3'd4;
   localparam logic [2:0] PH_PAUSE           = 3'd5;
   localparam logic [2:0] PH_STALLED         = 3'd6;
   localparam logic [2:0] PH_OUT_DATA        = 3'd7;

   // Endpoint handshake states.
   localparam logic [1:0] EP_NAK   = 2'd0;
   localparam logic [1:0] EP_VALID = 2'd1;
   localparam logic [1:0] EP_STALL = 2'd2;

   // Class handler verdicts.
   localparam logic [1:0] VERDICT_OK        = 2'd0;
   localparam logic [1:0] VERDICT_NOT_READY = 2'd1;

   // Event kinds.
   localparam logic ACT_SETUP = 1'b0;

   // Request type and recipient of a standard device request.
   localparam logic [1:0] KIND_STANDARD = 2'd0;
   localparam logic [4:0] RECIP_DEVICE  = 5'd0;

   localparam logic [7:0] REQ_ASSIGN_ADDR = 8'd5;

   // Register byte addresses.
   localparam logic [1:0] CSR_MPS_LOG2 = 2'd0;

   localparam logic [2:0] MPS_LOG2_MIN   = 3'd3;
   localparam logic [2:0] MPS_LOG2_MAX   = 3'd6;
   localparam logic [2:0] MPS_LOG2_RESET = 3'd6;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic        action;
      logic        dir;
      logic [1:0]  kind;
      logic [4:0]  recipient;
      logic [7:0]  code;
      logic [6:0]  address_byte;
      logic [15:0] length;
      logic [1:0]  reply_status;
      logic [15:0] reply_length;
   } item_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] remaining;
      logic [15:0] offset;
      logic        zlp_pending;
      logic [1:0]  tx_state;
      logic [1:0]  rx_state;
      logic [7:0]  saved_code;
      logic [1:0]  saved_kind;
      logic [4:0]  saved_recipient;
      logic [6:0]  saved_address;
      logic        attached;
   } state_type;

   typedef struct packed {
      logic [2:0]  ctrl_state;
      logic [1:0]  tx_status;
      logic [1:0]  rx_status;
      logic        send_valid;
      logic [15:0] send_offset;
      logic [6:0]  send_length;
      logic        addr_load;
      logic [6:0]  device_address;
      logic        attached;
   } result_type;

endpackage

FILE: sv/usb_ep0_control_transfer_fsm.sv
// Path: an accepted request is held in the input register; its result is loaded into
// the result register once that register is empty or draining.
// Throughput: one request per cycle unless the response side stalls; the step logic
// lies between the input and result registers; the transfer state advances each step.
// Reset (synchronous, active high): phase in_data, endpoints nak, counters and
// saved request cleared, max_packet_log2 back to 6, both channel stages empty.
module usb_ep0_control_transfer_fsm (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tuser: action
   input  logic        req_tuser,
   // tdata (low bit up): req_dir[0], req_kind[2:1], req_recipient[7:3],
   // req_code[15:8], req_address_byte[22:16], req_length[38:23],
   // reply_status[40:39], reply_length[56:41], zero pad [63:57]
   input  logic [uep0_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata (low bit up): ctrl_state[2:0], tx_status[4:3], rx_status[6:5],
   // send_valid[7], send_offset[23:8], send_length[30:24],
   // addr_load[31], device_address[38:32], attached[39]
   output logic [uep0_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [2:0] mps_log2;

   uep0_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .mps_log2 (mps_log2)
   );

   // Input stage: hold one request until the result register can take its result.
   logic                 in_vld_ff;
   logic                 in_vld_in;
   uep0_pkg::item_type   in_item_ff;
   uep0_pkg::item_type   req_item;

   // Result stage.
   logic                 out_vld_ff;
   logic                 out_vld_in;
   uep0_pkg::result_type out_res_ff;

   // Transfer state.
   uep0_pkg::state_type  state_ff;
   uep0_pkg::state_type  state_in;
   uep0_pkg::result_type step_res;

   logic                 advance;

   // Unpack the request payload.
   assign req_item.action       = req_tuser;
   assign req_item.dir          = req_tdata[0];
   assign req_item.kind         = req_tdata[2:1];
   assign req_item.recipient    = req_tdata[7:3];
   assign req_item.code         = req_tdata[15:8];
   assign req_item.address_byte = req_tdata[22:16];
   assign req_item.length       = req_tdata[38:23];
   assign req_item.reply_status = req_tdata[40:39];
   assign req_item.reply_length = req_tdata[56:41];

   // Step the held request when the result register is empty or draining.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   uep0_step u_step (
      .item     (in_item_ff),
      .cur      (state_ff),
      .mps_log2 (mps_log2),
      .nxt      (state_in),
      .res      (step_res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: load on handshake only.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_res_ff.attached,
                        out_res_ff.device_address,
                        out_res_ff.addr_load,
                        out_res_ff.send_length,
                        out_res_ff.send_offset,
                        out_res_ff.send_valid,
                        out_res_ff.rx_status,
                        out_res_ff.tx_status,
                        out_res_ff.ctrl_state};

endmodule

FILE: sv/uep0_csr.sv
module uep0_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [2:0]  mps_log2
);

   logic [2:0] mps_log2_ff;
   logic [2:0] mps_log2_in;

   always_comb begin
      mps_log2_in = mps_log2_ff;
      if (psel && penable && pwrite) begin
         mps_log2_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mps_log2_ff <= uep0_pkg::MPS_LOG2_RESET;
      end else begin
         mps_log2_ff <= mps_log2_in;
      end
   end

   assign pready   = 1'b1;
   assign prdata   = (paddr == uep0_pkg::CSR_MPS_LOG2) ? {29'd0, mps_log2_ff} : 32'd0;
   assign mps_log2 = mps_log2_ff;

endmodule

FILE: sv/uep0_step.sv
module uep0_step (
   input  uep0_pkg::item_type   item,
   input  uep0_pkg::state_type  cur,
   input  logic [2:0]           mps_log2,
   output uep0_pkg::state_type  nxt,
   output uep0_pkg::result_type res
);

   logic [2:0]  lg;
   logic [6:0]  mps;
   logic [15:0] mps_w;
   logic [15:0] clip;
   logic        zlp_setup;
   logic [15:0] chunk_rem;
   logic [15:0] chunk_off;
   logic [15:0] chunk_n;
   logic        chunk_last;
   logic        is_addr_req;

   always_comb begin
      lg = mps_log2;
      if (mps_log2 < uep0_pkg::MPS_LOG2_MIN) begin
         lg = uep0_pkg::MPS_LOG2_MIN;
      end else if (mps_log2 > uep0_pkg::MPS_LOG2_MAX) begin
         lg = uep0_pkg::MPS_LOG2_MAX;
      end
   end

   assign mps   = 7'd1 << lg;
   assign mps_w = {9'd0, mps};

   // Clip the offered reply to wLength.
   assign clip      = (item.reply_length > item.length) ? item.length : item.reply_length;
   assign zlp_setup = (clip >= mps_w) && ((clip & (mps_w - 16'd1)) == 16'd0);

   // Next chunk: from the fresh reply on setup, from saved progress on IN done.
   assign chunk_rem  = (item.action == uep0_pkg::ACT_SETUP) ? clip : cur.remaining;
   assign chunk_off  = (item.action == uep0_pkg::ACT_SETUP) ? 16'd0 : cur.offset;
   assign chunk_last = chunk_rem <= mps_w;
   assign chunk_n    = chunk_last ? chunk_rem : mps_w;

   assign is_addr_req = (cur.saved_code == uep0_pkg::REQ_ASSIGN_ADDR)
                     && (cur.saved_kind == uep0_pkg::KIND_STANDARD)
                     && (cur.saved_recipient == uep0_pkg::RECIP_DEVICE);

   always_comb begin
      nxt = cur;
      res = '0;
      if (item.action == uep0_pkg::ACT_SETUP) begin
         nxt.saved_code      = item.code;
         nxt.saved_kind      = item.kind;
         nxt.saved_recipient = item.recipient;
         nxt.saved_address   = item.address_byte;
         nxt.phase           = uep0_pkg::PH_SETTING_UP;
         if (item.length == 16'd0) begin
            res.send_valid = 1'b1;
            nxt.tx_state   = uep0_pkg::EP_VALID;
            nxt.phase      = uep0_pkg::PH_WAIT_STATUS_IN;
         end else if (item.reply_status == uep0_pkg::VERDICT_NOT_READY) begin
            nxt.phase = uep0_pkg::PH_PAUSE;
         end else if (item.reply_status != uep0_pkg::VERDICT_OK
                      || item.reply_length == 16'd0) begin
            nxt.phase    = uep0_pkg::PH_STALLED;
            nxt.tx_state = uep0_pkg::EP_STALL;
            nxt.rx_state = uep0_pkg::EP_STALL;
         end else if (item.dir) begin
            nxt.zlp_pending = zlp_setup;
            nxt.phase       = chunk_last ? uep0_pkg::PH_LAST_IN : uep0_pkg::PH_IN_DATA;
            nxt.remaining   = chunk_rem - chunk_n;
            nxt.offset      = chunk_off + chunk_n;
            nxt.tx_state    = uep0_pkg::EP_VALID;
            nxt.rx_state    = uep0_pkg::EP_VALID;
            res.send_valid  = 1'b1;
            res.send_offset = chunk_off;
            res.send_length = chunk_n[6:0];
         end else begin
            nxt.phase    = uep0_pkg::PH_OUT_DATA;
            nxt.rx_state = uep0_pkg::EP_VALID;
         end
      end else begin
         if (cur.phase == uep0_pkg::PH_IN_DATA || cur.phase == uep0_pkg::PH_LAST_IN) begin
            if (cur.remaining == 16'd0 && cur.phase == uep0_pkg::PH_LAST_IN) begin
               if (cur.zlp_pending) begin
                  res.send_valid  = 1'b1;
                  nxt.tx_state    = uep0_pkg::EP_VALID;
                  nxt.zlp_pending = 1'b0;
               end else begin
                  nxt.phase    = uep0_pkg::PH_WAIT_STATUS_OUT;
                  nxt.tx_state = uep0_pkg::EP_STALL;
               end
            end else begin
               nxt.phase       = chunk_last ? uep0_pkg::PH_LAST_IN : uep0_pkg::PH_IN_DATA;
               nxt.remaining   = chunk_rem - chunk_n;
               nxt.offset      = chunk_off + chunk_n;
               nxt.tx_state    = uep0_pkg::EP_VALID;
               nxt.rx_state    = uep0_pkg::EP_VALID;
               res.send_valid  = 1'b1;
               res.send_offset = chunk_off;
               res.send_length = chunk_n[6:0];
            end
         end else begin
            if (cur.phase == uep0_pkg::PH_WAIT_STATUS_IN && is_addr_req) begin
               res.addr_load      = 1'b1;
               res.device_address = cur.saved_address;
               nxt.attached       = 1'b1;
            end
            nxt.phase    = uep0_pkg::PH_STALLED;
            nxt.tx_state = uep0_pkg::EP_STALL;
            nxt.rx_state = uep0_pkg::EP_STALL;
         end
      end
      res.ctrl_state = nxt.phase;
      res.tx_status  = nxt.tx_state;
      res.rx_status  = nxt.rx_state;
      res.attached   = nxt.attached;
   end

endmodule

FILE: sv/uep0_checker.sv
`include "assert_macros.svh"

module uep0_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [uep0_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic rsp_stall;
   logic addr_out;
   logic all_stalled;
   logic pkt_armed;
   logic pkt_ok;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign addr_out    = rsp_tvalid && rsp_tdata[31];
   assign all_stalled = (rsp_tdata[2:0] == uep0_pkg::PH_STALLED)
                     && (rsp_tdata[4:3] == uep0_pkg::EP_STALL)
                     && (rsp_tdata[6:5] == uep0_pkg::EP_STALL);
   assign pkt_armed   = rsp_tvalid && rsp_tdata[7];
   assign pkt_ok      = (rsp_tdata[30:24] <= 7'd64)
                     && (rsp_tdata[4:3] == uep0_pkg::EP_VALID);

   // Hold a stalled response.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "response dropped while stalled")

   // An address handout always reports the device attached.
   `ASSERT_CLK(a_addr_attached, clock, reset, !addr_out || rsp_tdata[39], "address without attach")

   // An address handout ends the transfer with both directions stalled.
   `ASSERT_CLK(a_addr_stalled, clock, reset, !addr_out || all_stalled, "address outside stall")

   // An armed packet never exceeds the largest packet and leaves transmit valid.
   `ASSERT_CLK(a_pkt_size, clock, reset, !pkt_armed || pkt_ok, "armed packet malformed")

endmodule

bind usb_ep0_control_transfer_fsm uep0_checker u_checker (.*);

FILE: verif/usb_ep0_control_transfer_fsm_tb.sv
module usb_ep0_control_transfer_fsm_tb;

   localparam logic [1:0] VERDICT_UNSUPPORTED = 2'd2;
   localparam logic [1:0] VERDICT_UNKNOWN     = 2'd3;
   localparam logic       ACT_IN_DONE         = 1'b1;
   localparam int         LIMIT_CYCLES        = 400000;
   localparam int         ITEMS_PER_PHASE     = 188;
   localparam int         MAX_INS_PER_XFER    = 40;

   typedef struct {
      uep0_pkg::item_type   stim;
      bit                   typed;
      uep0_pkg::result_type want;
   } dir_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic                             req_tuser;
   logic [uep0_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [uep0_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [1:0]                       csr_paddr;
   logic [31:0]                      csr_pwdata;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;

   // Transfer state mirrored from the block.
   logic [2:0]  xfer_phase;
   logic [15:0] bytes_left;
   logic [15:0] chunk_offset;
   logic        zlp_owed;
   logic [1:0]  tx_ep;
   logic [1:0]  rx_ep;
   logic [7:0]  last_code;
   logic [1:0]  last_kind;
   logic [4:0]  last_recip;
   logic [6:0]  last_addr;
   logic        attached_q;
   logic [2:0]  mps_log2;

   uep0_pkg::result_type pending_rsp[$];
   int                   fail_count;
   int                   items_sent;
   int                   cycle_count;
   int                   send_idle_pct;
   int                   recv_stall_pct;
   dir_row_type          dir_rows[25];

   usb_ep0_control_transfer_fsm u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int pkt_bytes();
      logic [2:0] lg;
      lg = mps_log2;
      if (lg < uep0_pkg::MPS_LOG2_MIN) lg = uep0_pkg::MPS_LOG2_MIN;
      if (lg > uep0_pkg::MPS_LOG2_MAX) lg = uep0_pkg::MPS_LOG2_MAX;
      return 1 << lg;
   endfunction

   // Arm the next chunk, the trailing zero-length packet, or close the data stage.
   function automatic void send_chunk(inout uep0_pkg::result_type r);
      int n;
      n = pkt_bytes();
      if (bytes_left == 16'd0 && xfer_phase == uep0_pkg::PH_LAST_IN) begin
         if (zlp_owed) begin
            r.send_valid  = 1'b1;
            r.send_offset = 16'd0;
            r.send_length = 7'd0;
            tx_ep         = uep0_pkg::EP_VALID;
            zlp_owed      = 1'b0;
         end else begin
            xfer_phase = uep0_pkg::PH_WAIT_STATUS_OUT;
            tx_ep      = uep0_pkg::EP_STALL;
         end
      end else begin
         xfer_phase = (int'(bytes_left) <= n) ? uep0_pkg::PH_LAST_IN : uep0_pkg::PH_IN_DATA;
         if (n > int'(bytes_left)) n = int'(bytes_left);
         r.send_valid  = 1'b1;
         r.send_offset = chunk_offset;
         r.send_length = n[6:0];
         bytes_left    = bytes_left - n[15:0];
         chunk_offset  = chunk_offset + n[15:0];
         tx_ep         = uep0_pkg::EP_VALID;
         rx_ep         = uep0_pkg::EP_VALID;
      end
   endfunction

   function automatic uep0_pkg::result_type step_transfer(uep0_pkg::item_type it);
      uep0_pkg::result_type r;
      int                   clip;
      int                   mps;
      r = '0;
      if (it.action == uep0_pkg::ACT_SETUP) begin
         last_code  = it.code;
         last_kind  = it.kind;
         last_recip = it.recipient;
         last_addr  = it.address_byte;
         xfer_phase = uep0_pkg::PH_SETTING_UP;
         if (it.length == 16'd0) begin
            r.send_valid = 1'b1;
            tx_ep        = uep0_pkg::EP_VALID;
            xfer_phase   = uep0_pkg::PH_WAIT_STATUS_IN;
         end else if (it.reply_status == uep0_pkg::VERDICT_NOT_READY) begin
            xfer_phase = uep0_pkg::PH_PAUSE;
         end else if (it.reply_status != uep0_pkg::VERDICT_OK || it.reply_length == 16'd0) begin
            xfer_phase = uep0_pkg::PH_STALLED;
            rx_ep      = uep0_pkg::EP_STALL;
            tx_ep      = uep0_pkg::EP_STALL;
         end else if (it.dir) begin
            mps  = pkt_bytes();
            clip = (it.reply_length > it.length) ? int'(it.length) : int'(it.reply_length);
            bytes_left   = clip[15:0];
            chunk_offset = 16'd0;
            zlp_owed     = (clip >= mps && (clip & (mps - 1)) == 0);
            send_chunk(r);
         end else begin
            xfer_phase = uep0_pkg::PH_OUT_DATA;
            rx_ep      = uep0_pkg::EP_VALID;
         end
      end else begin
         if (xfer_phase == uep0_pkg::PH_IN_DATA || xfer_phase == uep0_pkg::PH_LAST_IN) begin
            send_chunk(r);
         end else begin
            // Status stage of a standard device address request hands out the address.
            if (xfer_phase == uep0_pkg::PH_WAIT_STATUS_IN &&
                last_code == uep0_pkg::REQ_ASSIGN_ADDR &&
                last_kind == uep0_pkg::KIND_STANDARD &&
                last_recip == uep0_pkg::RECIP_DEVICE) begin
               r.addr_load      = 1'b1;
               r.device_address = last_addr;
               attached_q       = 1'b1;
            end
            xfer_phase = uep0_pkg::PH_STALLED;
         end
         if (xfer_phase == uep0_pkg::PH_STALLED) begin
            rx_ep = uep0_pkg::EP_STALL;
            tx_ep = uep0_pkg::EP_STALL;
         end
      end
      r.ctrl_state = xfer_phase;
      r.tx_status  = tx_ep;
      r.rx_status  = rx_ep;
      r.attached   = attached_q;
      return r;
   endfunction

   function automatic uep0_pkg::item_type mk_setup(logic d, logic [1:0] k, logic [4:0] rc,
                                                   logic [7:0] c, logic [6:0] a,
                                                   logic [15:0] wl, logic [1:0] st,
                                                   logic [15:0] rl);
      uep0_pkg::item_type it;
      it.action       = uep0_pkg::ACT_SETUP;
      it.dir          = d;
      it.kind         = k;
      it.recipient    = rc;
      it.code         = c;
      it.address_byte = a;
      it.length       = wl;
      it.reply_status = st;
      it.reply_length = rl;
      return it;
   endfunction

   function automatic uep0_pkg::item_type mk_in();
      uep0_pkg::item_type it;
      it        = '0;
      it.action = ACT_IN_DONE;
      return it;
   endfunction

   function automatic uep0_pkg::result_type mk_res(logic [2:0] st, logic [1:0] tx,
                                                   logic [1:0] rx, logic sv,
                                                   logic [15:0] off, logic [6:0] len,
                                                   logic av, logic [6:0] addr, logic att);
      uep0_pkg::result_type r;
      r.ctrl_state     = st;
      r.tx_status      = tx;
      r.rx_status      = rx;
      r.send_valid     = sv;
      r.send_offset    = off;
      r.send_length    = len;
      r.addr_load      = av;
      r.device_address = addr;
      r.attached       = att;
      return r;
   endfunction

   function automatic uep0_pkg::item_type rand_item();
      uep0_pkg::item_type it;
      it.action       = 1'($urandom_range(1));
      it.dir          = 1'($urandom_range(1));
      it.kind         = 2'($urandom_range(3));
      it.recipient    = 5'($urandom_range(31));
      it.code         = 8'($urandom_range(255));
      it.address_byte = 7'($urandom_range(127));
      it.length       = 16'($urandom_range(65535));
      it.reply_status = 2'($urandom_range(3));
      it.reply_length = 16'($urandom_range(65535));
      return it;
   endfunction

   // Mostly well-formed setups: supported verdicts, short replies, device recipient.
   function automatic uep0_pkg::item_type rand_setup();
      uep0_pkg::item_type it;
      int                 r;
      it        = rand_item();
      it.action = uep0_pkg::ACT_SETUP;
      it.dir    = ($urandom_range(99) < 75);
      if ($urandom_range(99) < 80) begin
         it.kind      = uep0_pkg::KIND_STANDARD;
         it.recipient = uep0_pkg::RECIP_DEVICE;
      end
      if ($urandom_range(99) < 25) it.code = uep0_pkg::REQ_ASSIGN_ADDR;
      r = $urandom_range(99);
      if (r < 12) it.length = 16'd0;
      else if (r >= 22) it.length = 16'($urandom_range(300, 1));
      it.reply_status = ($urandom_range(99) < 85) ? uep0_pkg::VERDICT_OK
                                                  : 2'($urandom_range(3));
      r = $urandom_range(99);
      if (r < 5) it.reply_length = 16'd0;
      else if (r < 15) it.reply_length = 16'($urandom_range(65535));
      else if (r < 45) it.reply_length = it.length;
      else if (r < 65) it.reply_length = 16'(pkt_bytes() * $urandom_range(6, 1));
      else it.reply_length = 16'($urandom_range(300, 1));
      return it;
   endfunction

   function void check_field(string nm, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, nm, want, got);
         fail_count++;
      end
   endfunction

   // Hold the request until it is taken, then record what it should produce.
   task automatic issue_request(input uep0_pkg::item_type it, input bit typed,
                                input uep0_pkg::result_type want);
      uep0_pkg::result_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {7'd0, it.reply_length, it.reply_status, it.length, it.address_byte,
                     it.code, it.recipient, it.kind, it.dir};
      do @(posedge clock); while (!req_tready);
      pred = step_transfer(it);
      pending_rsp.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_mps(input logic [2:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= uep0_pkg::CSR_MPS_LOG2;
      csr_pwdata  <= {29'd0, v};
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mps_log2 = v;
   endtask

   // Mostly a setup, then IN completions while it expects them; else a random request.
   task automatic run_traffic(input int n_items);
      int                 start;
      int                 ins;
      uep0_pkg::item_type it;
      start = items_sent;
      while (items_sent - start < n_items) begin
         if ($urandom_range(99) < 75) begin
            issue_request(rand_setup(), 1'b0, '0);
            ins = 0;
            while ((xfer_phase == uep0_pkg::PH_IN_DATA || xfer_phase == uep0_pkg::PH_LAST_IN ||
                    xfer_phase == uep0_pkg::PH_WAIT_STATUS_IN) && ins < MAX_INS_PER_XFER) begin
               it        = rand_item();
               it.action = ACT_IN_DONE;
               issue_request(it, 1'b0, '0);
               ins++;
            end
            if ($urandom_range(1)) begin
               it        = rand_item();
               it.action = ACT_IN_DONE;
               issue_request(it, 1'b0, '0);
            end
         end else begin
            issue_request(rand_item(), 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      uep0_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with none pending, expected none actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("ctrl_state", int'(want.ctrl_state), int'(rsp_tdata[2:0]));
            check_field("tx_status", int'(want.tx_status), int'(rsp_tdata[4:3]));
            check_field("rx_status", int'(want.rx_status), int'(rsp_tdata[6:5]));
            check_field("send_valid", int'(want.send_valid), int'(rsp_tdata[7]));
            check_field("send_offset", int'(want.send_offset), int'(rsp_tdata[23:8]));
            check_field("send_length", int'(want.send_length), int'(rsp_tdata[30:24]));
            check_field("addr_load", int'(want.addr_load), int'(rsp_tdata[31]));
            check_field("device_address", int'(want.device_address),
                        int'(rsp_tdata[38:32]));
            check_field("attached", int'(want.attached), int'(rsp_tdata[39]));
         end
      end
   end

   initial begin
      logic [2:0] mps_plan[8];
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      items_sent     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      xfer_phase   = uep0_pkg::PH_IN_DATA;
      bytes_left   = '0;
      chunk_offset = '0;
      zlp_owed     = 1'b0;
      tx_ep        = uep0_pkg::EP_NAK;
      rx_ep        = uep0_pkg::EP_NAK;
      last_code    = '0;
      last_kind    = '0;
      last_recip   = '0;
      last_addr    = '0;
      attached_q   = 1'b0;
      mps_log2     = uep0_pkg::MPS_LOG2_RESET;
      mps_plan     = '{3'd3, 3'd0, 3'd6, 3'd7, 3'd4, 3'd1, 3'd5, 3'd2};

      // IN completions straight after reset, then each verdict, then the data paths.
      dir_rows[0]  = '{mk_in(), 1'b1,
                       mk_res(uep0_pkg::PH_LAST_IN, uep0_pkg::EP_VALID, uep0_pkg::EP_VALID,
                              1'b1, 16'd0, 7'd0, 1'b0, 7'd0, 1'b0)};
      dir_rows[1]  = '{mk_in(), 1'b1,
                       mk_res(uep0_pkg::PH_WAIT_STATUS_OUT, uep0_pkg::EP_STALL,
                              uep0_pkg::EP_VALID, 1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b0)};
      dir_rows[2]  = '{mk_in(), 1'b1,
                       mk_res(uep0_pkg::PH_STALLED, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b0)};
      dir_rows[3]  = '{mk_setup(1'b0, 2'd0, 5'd0, uep0_pkg::REQ_ASSIGN_ADDR, 7'd127, 16'd0,
                                VERDICT_UNSUPPORTED, 16'hFFFF), 1'b1,
                       mk_res(uep0_pkg::PH_WAIT_STATUS_IN, uep0_pkg::EP_VALID,
                              uep0_pkg::EP_STALL, 1'b1, 16'd0, 7'd0, 1'b0, 7'd0, 1'b0)};
      dir_rows[4]  = '{mk_in(), 1'b1,
                       mk_res(uep0_pkg::PH_STALLED, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b1, 7'd127, 1'b1)};
      dir_rows[5]  = '{mk_setup(1'b1, 2'd0, 5'd0, 8'h06, 7'd0, 16'hFFFF,
                                uep0_pkg::VERDICT_NOT_READY, 16'hFFFF), 1'b1,
                       mk_res(uep0_pkg::PH_PAUSE, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b1)};
      dir_rows[6]  = '{mk_in(), 1'b1,
                       mk_res(uep0_pkg::PH_STALLED, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b1)};
      dir_rows[7]  = '{mk_setup(1'b1, 2'd1, 5'd1, 8'h01, 7'd0, 16'd1, VERDICT_UNSUPPORTED,
                                16'd5), 1'b1,
                       mk_res(uep0_pkg::PH_STALLED, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b1)};
      dir_rows[8]  = '{mk_setup(1'b1, 2'd2, 5'd2, 8'h02, 7'd0, 16'd1, VERDICT_UNKNOWN,
                                16'd5), 1'b1,
                       mk_res(uep0_pkg::PH_STALLED, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b1)};
      dir_rows[9]  = '{mk_setup(1'b1, 2'd0, 5'd0, 8'h06, 7'd0, 16'd1, uep0_pkg::VERDICT_OK,
                                16'd0), 1'b1,
                       mk_res(uep0_pkg::PH_STALLED, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b1)};
      dir_rows[10] = '{mk_setup(1'b0, 2'd1, 5'd0, 8'h09, 7'd0, 16'd100, uep0_pkg::VERDICT_OK,
                                16'd100), 1'b1,
                       mk_res(uep0_pkg::PH_OUT_DATA, uep0_pkg::EP_STALL, uep0_pkg::EP_VALID,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b1)};
      dir_rows[11] = '{mk_in(), 1'b1,
                       mk_res(uep0_pkg::PH_STALLED, uep0_pkg::EP_STALL, uep0_pkg::EP_STALL,
                              1'b0, 16'd0, 7'd0, 1'b0, 7'd0, 1'b1)};
      // Two full packets plus the trailing zero-length packet.
      dir_rows[12] = '{mk_setup(1'b1, 2'd3, 5'd31, 8'hFF, 7'h55, 16'hFFFF,
                                uep0_pkg::VERDICT_OK, 16'd128), 1'b0, '0};
      dir_rows[13] = '{mk_in(), 1'b0, '0};
      dir_rows[14] = '{mk_in(), 1'b0, '0};
      dir_rows[15] = '{mk_in(), 1'b0, '0};
      // Reply clipped to wLength.
      dir_rows[16] = '{mk_setup(1'b1, 2'd0, 5'd0, 8'h06, 7'h2A, 16'd10, uep0_pkg::VERDICT_OK,
                                16'hFFFF), 1'b0, '0};
      dir_rows[17] = '{mk_in(), 1'b0, '0};
      // Address request that is class or not device recipient hands out nothing.
      dir_rows[18] = '{mk_setup(1'b0, 2'd1, 5'd0, uep0_pkg::REQ_ASSIGN_ADDR, 7'h11, 16'd0,
                                uep0_pkg::VERDICT_OK, 16'd0), 1'b0, '0};
      dir_rows[19] = '{mk_in(), 1'b0, '0};
      dir_rows[20] = '{mk_setup(1'b0, 2'd0, 5'd1, uep0_pkg::REQ_ASSIGN_ADDR, 7'h22, 16'd0,
                                uep0_pkg::VERDICT_OK, 16'd0), 1'b0, '0};
      dir_rows[21] = '{mk_in(), 1'b0, '0};
      // New setup in the middle of a data stage.
      dir_rows[22] = '{mk_setup(1'b1, 2'd0, 5'd0, 8'h06, 7'd0, 16'd200, uep0_pkg::VERDICT_OK,
                                16'd200), 1'b0, '0};
      dir_rows[23] = '{mk_setup(1'b0, 2'd0, 5'd0, uep0_pkg::REQ_ASSIGN_ADDR, 7'd0, 16'd0,
                                uep0_pkg::VERDICT_OK, 16'd0), 1'b0, '0};
      dir_rows[24] = '{mk_in(), 1'b0, '0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) issue_request(dir_rows[i].stim, dir_rows[i].typed,
                                          dir_rows[i].want);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         write_mps(mps_plan[p]);
         run_traffic(ITEMS_PER_PHASE);
         drain();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/uep0_pkg.sv
sv/uep0_csr.sv
sv/uep0_step.sv
sv/usb_ep0_control_transfer_fsm.sv
sv/uep0_checker.sv
verif/usb_ep0_control_transfer_fsm_tb.sv
